// File: src/abc_pkg.sv
package abc_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned TAB_DEPTH  = 256;
    localparam int unsigned TAB_AW     = $clog2(TAB_DEPTH);
    localparam int unsigned SEED_W     = 22;
    localparam int unsigned HALF_W     = 16;
    localparam int unsigned REGION_CNT = 5;

    localparam logic [WORD_W-1:0] KEY_B_INIT = 32'hEEEE_EEEE;
    localparam logic [WORD_W-1:0] KEY_A_ADD  = 32'h1111_1111;
    localparam logic [WORD_W-1:0] KEY_B_ADD  = 32'd3;

    localparam logic [SEED_W-1:0] LCG_START  = 22'h10_0001;
    localparam logic [SEED_W-1:0] LCG_MOD    = 22'h2A_AAAB;
    localparam logic [6:0]        LCG_MUL    = 7'd125;
    localparam logic [1:0]        LCG_ADD    = 2'd3;

    localparam logic KIND_SEED = 1'b0;
    localparam logic KIND_DATA = 1'b1;
    localparam logic MODE_DEC  = 1'b0;
    localparam logic MODE_ENC  = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] value;
        logic              last_word;
    } t_in;

    typedef struct packed {
        logic [WORD_W-1:0] word_out;
        logic              last_out;
    } t_out;

    typedef struct packed {
        logic              we;
        logic [TAB_AW-1:0] addr;
        logic [WORD_W-1:0] data;
    } t_tab_wr;

endpackage

// File: src/abc_tab_gen.sv
module abc_tab_gen (
    input  logic            i_clk,
    input  logic            i_rst_n,
    output abc_pkg::t_tab_wr o_wr,
    output logic            o_done
);
    import abc_pkg::*;

    localparam logic [1:0] ST_MUL  = 2'd0;
    localparam logic [1:0] ST_QUO  = 2'd1;
    localparam logic [1:0] ST_RED  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam int unsigned X_W   = 29;
    localparam int unsigned Q_W   = 8;
    localparam int unsigned D_W   = 31;
    localparam int unsigned REG_W = 3;

    logic [1:0]        r_state, n_state;
    logic [SEED_W-1:0] r_seed;
    logic [X_W-1:0]    r_x;
    logic [Q_W-1:0]    r_q;
    logic [HALF_W-1:0] r_hi;
    logic              r_half;
    logic [REG_W-1:0]  r_region;
    logic [TAB_AW-1:0] r_pos;

    logic [D_W-1:0]    x3;
    logic [D_W-1:0]    prod;
    logic [D_W-1:0]    diff;
    logic [D_W-1:0]    fixed_r;
    logic [SEED_W-1:0] new_seed;
    logic              last_region;
    logic              last_step;

    assign x3       = {2'b00, r_x} + {1'b0, r_x, 1'b0};
    assign prod     = D_W'(r_q) * D_W'(LCG_MOD);
    assign diff     = {2'b00, r_x} - prod;
    assign fixed_r  = diff[D_W-1] ? diff + D_W'(LCG_MOD) : diff;
    assign new_seed = fixed_r[SEED_W-1:0];

    assign last_region = (r_region == REG_W'(REGION_CNT - 1));
    assign last_step   = last_region && r_half && (r_pos == TAB_AW'(TAB_DEPTH - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_MUL:  n_state = ST_QUO;
            ST_QUO:  n_state = ST_RED;
            ST_RED:  n_state = last_step ? ST_DONE : ST_MUL;
            ST_DONE: n_state = ST_DONE;
            default: n_state = ST_DONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_MUL;
            r_seed   <= LCG_START;
            r_half   <= 1'b0;
            r_region <= '0;
            r_pos    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_RED) begin
                r_seed <= new_seed;
                r_half <= ~r_half;
                if (r_half) begin
                    if (last_region) begin
                        r_region <= '0;
                        r_pos    <= r_pos + 1'b1;
                    end else begin
                        r_region <= r_region + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) begin
            r_x <= X_W'(r_seed) * X_W'(LCG_MUL) + X_W'(LCG_ADD);
        end
        if (r_state == ST_QUO) begin
            r_q <= x3[D_W-1 -: Q_W];
        end
        if (r_state == ST_RED && !r_half) begin
            r_hi <= new_seed[HALF_W-1:0];
        end
    end

    assign o_wr.we   = (r_state == ST_RED) && r_half && last_region;
    assign o_wr.addr = r_pos;
    assign o_wr.data = {r_hi, new_seed[HALF_W-1:0]};
    assign o_done    = (r_state == ST_DONE);

endmodule

// File: src/abc_mix_ram.sv
module abc_mix_ram (
    input  logic                               i_clk,
    input  abc_pkg::t_tab_wr                   i_wr,
    input  logic                               i_rd_en,
    input  logic [abc_pkg::TAB_AW-1:0]         i_rd_addr,
    output logic [abc_pkg::WORD_W-1:0]         o_rd_data
);
    import abc_pkg::*;

    logic [WORD_W-1:0] mem [TAB_DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/archive_block_cipher.sv
// Path: a data word passes the stage-one register, then the output register.
// Throughput: one item per cycle unless the output stalls; key A and the table read
// advance at input transfer, key B in the second stage, each a single-register loop.
// Reset: synchronous, active low; keys and mode return to their initial values and the
// 256-word mix table is regenerated, with the input stalled throughout.
module archive_block_cipher (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  abc_pkg::t_in                i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output abc_pkg::t_out               o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_data
);
    import abc_pkg::*;

    t_tab_wr           tab_wr;
    logic              fill_done;
    logic [WORD_W-1:0] tab_q;

    logic              r_mode;
    logic [WORD_W-1:0] r_key_a;
    logic [WORD_W-1:0] r_key_b;
    logic              r_s1_vld;
    t_in               r_s1_item;
    logic [WORD_W-1:0] r_s1_key_a;
    logic              r_out_vld;
    t_out              r_out_data;

    logic              in_xfer;
    logic              out_free;
    logic              s1_adv;
    logic              s1_data;
    logic [WORD_W-1:0] key_a_mix;
    logic [WORD_W-1:0] kb1;
    logic [WORD_W-1:0] res;
    logic [WORD_W-1:0] plain;
    logic [WORD_W-1:0] kb_next;

    abc_tab_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_wr    (tab_wr),
        .o_done  (fill_done)
    );

    abc_mix_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (tab_wr),
        .i_rd_en   (in_xfer),
        .i_rd_addr (r_key_a[TAB_AW-1:0]),
        .o_rd_data (tab_q)
    );

    assign s1_data    = (r_s1_item.kind == KIND_DATA);
    assign out_free   = !r_out_vld || !i_out_stall;
    assign s1_adv     = r_s1_vld && (!s1_data || out_free);
    assign o_in_stall = !fill_done || (r_s1_vld && !s1_adv);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign key_a_mix = ((~r_key_a << 21) + KEY_A_ADD) | (r_key_a >> 11);

    assign kb1     = r_key_b + tab_q;
    assign res     = r_s1_item.value ^ (r_s1_key_a + kb1);
    assign plain   = (r_mode == MODE_ENC) ? r_s1_item.value : res;
    assign kb_next = plain + kb1 + (kb1 << 5) + KEY_B_ADD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_DEC;
            r_key_a   <= '0;
            r_key_b   <= KEY_B_INIT;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
            if (in_xfer) begin
                r_key_a <= (i_in_data.kind == KIND_SEED) ? i_in_data.value : key_a_mix;
            end
            if (s1_adv || !r_s1_vld) begin
                r_s1_vld <= in_xfer;
            end
            if (s1_adv) begin
                r_key_b <= s1_data ? kb_next : KEY_B_INIT;
            end
            if (s1_adv && s1_data) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_item  <= i_in_data;
            r_s1_key_a <= r_key_a;
        end
        if (s1_adv && s1_data) begin
            r_out_data.word_out <= res;
            r_out_data.last_out <= r_s1_item.last_word;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    a_fill_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fill_done |-> o_in_stall)
        else $error("input taken before the mix table is filled");

    a_seed_key_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && !s1_data |=> r_key_b == KEY_B_INIT)
        else $error("key B not reloaded after seed");

    a_data_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && s1_data |=> r_out_vld)
        else $error("data word lost between stage and output register");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && s1_data && r_out_vld && i_out_stall |-> o_in_stall)
        else $error("input taken while the data stage is blocked");

endmodule
